/* rtl/tlg_pkg.sv */
// shared types, codes and time helpers for the toggle request guard
package tlg_pkg;

    localparam int TIME_BITS = 48;
    localparam int CFG_BITS  = 16;

    localparam logic [CFG_BITS-1:0] TIMEOUT_RESET = 16'd2000;
    localparam logic [CFG_BITS-1:0] SETTLE_RESET  = 16'd300;

    // register word index on the config port
    localparam logic REG_TIMEOUT = 1'b0;
    localparam logic REG_SETTLE  = 1'b1;

    typedef enum logic [1:0] {
        OP_STEP  = 2'd0,
        OP_CMD   = 2'd1,
        OP_CLEAR = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        DEC_NONE     = 2'd0,
        DEC_DISPATCH = 2'd1,
        DEC_DROPPED  = 2'd2
    } t_dec;

    typedef logic [TIME_BITS-1:0] t_time;

    typedef struct packed {
        logic [CFG_BITS-1:0] timeout_ms;
        logic [CFG_BITS-1:0] settle_ms;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic       pend_req;
        logic       ctx_ok;
        logic       streaming;
        t_time      transition_time;
        t_time      now_time;
        logic       arm_request;
        logic       sent_state;
    } t_item;

    // (a - b) >= lim with a signed, unwrapped difference
    function automatic logic diff_ge(t_time a, t_time b, logic [CFG_BITS-1:0] lim);
        logic [TIME_BITS:0] d;
        d = {1'b0, a} - {1'b0, b};
        return !d[TIME_BITS] && (d[TIME_BITS-1:0] >= {{(TIME_BITS-CFG_BITS){1'b0}}, lim});
    endfunction

    // (a - b) > lim with a signed, unwrapped difference
    function automatic logic diff_gt(t_time a, t_time b, logic [CFG_BITS-1:0] lim);
        logic [TIME_BITS:0] d;
        d = {1'b0, a} - {1'b0, b};
        return !d[TIME_BITS] && (d[TIME_BITS-1:0] > {{(TIME_BITS-CFG_BITS){1'b0}}, lim});
    endfunction

endpackage

/* rtl/tlg_regs.sv */
// apb configuration registers: timeout and settle times
module tlg_regs (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready,
    output tlg_pkg::t_cfg       o_cfg
);

    logic [tlg_pkg::CFG_BITS-1:0] r_timeout;
    logic [tlg_pkg::CFG_BITS-1:0] r_settle;
    logic                         wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout <= tlg_pkg::TIMEOUT_RESET;
            r_settle  <= tlg_pkg::SETTLE_RESET;
        end else if (wr_en) begin
            unique case (paddr[2])
                tlg_pkg::REG_TIMEOUT: r_timeout <= pwdata[tlg_pkg::CFG_BITS-1:0];
                tlg_pkg::REG_SETTLE:  r_settle  <= pwdata[tlg_pkg::CFG_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            tlg_pkg::REG_TIMEOUT: prdata = {{(32-tlg_pkg::CFG_BITS){1'b0}}, r_timeout};
            tlg_pkg::REG_SETTLE:  prdata = {{(32-tlg_pkg::CFG_BITS){1'b0}}, r_settle};
            default:              prdata = '0;
        endcase
    end

    assign o_cfg.timeout_ms = r_timeout;
    assign o_cfg.settle_ms  = r_settle;

endmodule

/* rtl/tlg_core.sv */
// guard state and the per-item decision logic
module tlg_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_fire,
    input  tlg_pkg::t_item i_item,
    input  tlg_pkg::t_cfg  i_cfg,
    output tlg_pkg::t_dec  o_dec
);

    logic           r_waiting, n_waiting;
    logic           r_armed, n_armed;
    logic           r_queued, n_queued;
    logic           r_sent_ss, n_sent_ss;
    logic           r_ts, n_ts;
    tlg_pkg::t_time r_seen, n_seen;
    tlg_pkg::t_time r_sent_time, n_sent_time;

    logic           departed;
    logic           q;
    logic           ts_upd;
    tlg_pkg::t_time seen_upd;
    logic           live;
    logic           drop_late;
    logic           disp_ok;
    logic           timed_out;

    assign departed = i_item.streaming != r_sent_ss;
    assign q        = r_queued || i_item.pend_req;
    // a fresh nonzero transition time replaces the seen one
    assign ts_upd   = departed && ((i_item.transition_time != '0) || r_ts);
    assign seen_upd = !departed ? '0 :
                      (i_item.transition_time != '0) ? i_item.transition_time : r_seen;
    assign live     = q && ts_upd && departed;

    assign drop_late = live && tlg_pkg::diff_gt(seen_upd, r_sent_time, i_cfg.timeout_ms);
    assign disp_ok   = live
                    && tlg_pkg::diff_ge(i_item.now_time, r_sent_time, i_cfg.settle_ms)
                    && tlg_pkg::diff_ge(i_item.now_time, seen_upd, i_cfg.settle_ms);
    assign timed_out = !departed
                    && tlg_pkg::diff_ge(i_item.now_time, r_sent_time, i_cfg.timeout_ms);

    always_comb begin
        n_waiting   = r_waiting;
        n_armed     = r_armed;
        n_queued    = r_queued;
        n_sent_ss   = r_sent_ss;
        n_ts        = r_ts;
        n_seen      = r_seen;
        n_sent_time = r_sent_time;
        o_dec       = tlg_pkg::DEC_NONE;

        case (i_item.op)
            tlg_pkg::OP_STEP: begin
                if (!i_item.ctx_ok) begin
                    n_waiting   = 1'b0;
                    n_armed     = 1'b0;
                    n_queued    = 1'b0;
                    n_sent_ss   = 1'b0;
                    n_ts        = 1'b0;
                    n_seen      = '0;
                    n_sent_time = '0;
                end else if (!r_waiting) begin
                    // idle guard passes the request straight through
                    o_dec = i_item.pend_req ? tlg_pkg::DEC_DISPATCH
                                            : tlg_pkg::DEC_NONE;
                end else if (r_armed) begin
                    if (drop_late || timed_out) begin
                        n_waiting   = 1'b0;
                        n_armed     = 1'b0;
                        n_queued    = 1'b0;
                        n_sent_ss   = 1'b0;
                        n_ts        = 1'b0;
                        n_seen      = '0;
                        n_sent_time = '0;
                        o_dec = (drop_late || q) ? tlg_pkg::DEC_DROPPED
                                                 : tlg_pkg::DEC_NONE;
                    end else if (disp_ok) begin
                        n_queued  = 1'b0;
                        n_waiting = 1'b0;
                        n_ts      = 1'b0;
                        n_seen    = seen_upd;
                        o_dec     = tlg_pkg::DEC_DISPATCH;
                    end else begin
                        n_queued = q;
                        n_ts     = ts_upd;
                        n_seen   = seen_upd;
                    end
                end
            end
            tlg_pkg::OP_CMD: begin
                if (i_item.arm_request) begin
                    n_waiting   = 1'b1;
                    n_armed     = 1'b1;
                    n_sent_ss   = i_item.sent_state;
                    n_ts        = 1'b0;
                    n_sent_time = i_item.now_time;
                end else begin
                    n_waiting   = 1'b0;
                    n_armed     = 1'b0;
                    n_queued    = 1'b0;
                    n_sent_ss   = 1'b0;
                    n_ts        = 1'b0;
                    n_seen      = '0;
                    n_sent_time = '0;
                end
            end
            tlg_pkg::OP_CLEAR: begin
                n_waiting   = 1'b0;
                n_armed     = 1'b0;
                n_queued    = 1'b0;
                n_sent_ss   = 1'b0;
                n_ts        = 1'b0;
                n_seen      = '0;
                n_sent_time = '0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_waiting   <= 1'b0;
            r_armed     <= 1'b0;
            r_queued    <= 1'b0;
            r_sent_ss   <= 1'b0;
            r_ts        <= 1'b0;
            r_seen      <= '0;
            r_sent_time <= '0;
        end else if (i_fire) begin
            r_waiting   <= n_waiting;
            r_armed     <= n_armed;
            r_queued    <= n_queued;
            r_sent_ss   <= n_sent_ss;
            r_ts        <= n_ts;
            r_seen      <= n_seen;
            r_sent_time <= n_sent_time;
        end
    end

endmodule

/* rtl/toggle_request_guard.sv */
// top level of the toggle request guard: input register, core, result register
//
//  channel   dir   handshake                 payload
//  s_axis    in    tvalid/tready             tuser: op, tdata: step/command fields
//  m_axis    out   tvalid/tready             tdata: decision
//  apb       in    psel/penable/pready       two 16-bit registers
//
// an item's result passes from the input register through the decision logic into
// the result register, from which the m_axis side takes it.
// one item per cycle is sustained while the sink is ready; the decision logic and guard state update
// sit in the single stage between the two registers.
// reset (synchronous, active low) empties both registers and clears the guard.
// a stalled result holds its register; the input side keeps accepting until
// both registers are full.
module toggle_request_guard (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [103:0]  s_axis_tdata,  // pend_req, ctx_ok, streaming,
                                         // transition_time[47:0], now_time[47:0],
                                         // arm_request, sent_state, zero pad
    input  logic [1:0]    s_axis_tuser,  // op
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,  // decision[1:0], zero pad
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);

    localparam int TB = tlg_pkg::TIME_BITS;

    tlg_pkg::t_cfg  cfg;
    tlg_pkg::t_item r_item;
    tlg_pkg::t_item n_item;
    tlg_pkg::t_dec  dec;
    tlg_pkg::t_dec  r_dec;
    logic           r_in_vld;
    logic           r_out_vld;
    logic           out_free;
    logic           fire;
    logic           take;

    assign out_free      = !r_out_vld || m_axis_tready;
    assign fire          = r_in_vld && out_free;
    assign s_axis_tready = !r_in_vld || out_free;
    assign take          = s_axis_tvalid && s_axis_tready;

    assign n_item.op              = s_axis_tuser;
    assign n_item.pend_req        = s_axis_tdata[0];
    assign n_item.ctx_ok          = s_axis_tdata[1];
    assign n_item.streaming       = s_axis_tdata[2];
    assign n_item.transition_time = s_axis_tdata[3 +: TB];
    assign n_item.now_time        = s_axis_tdata[3 + TB +: TB];
    assign n_item.arm_request     = s_axis_tdata[3 + 2*TB];
    assign n_item.sent_state      = s_axis_tdata[4 + 2*TB];

    tlg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    tlg_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_cfg   (cfg),
        .o_dec   (dec)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (take) begin
            r_in_vld <= 1'b1;
        end else if (fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_item <= n_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_dec <= dec;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {6'd0, r_dec};

endmodule

/* rtl/tlg_checker.sv */
// port-level checks for the toggle request guard, bound to the top level
module tlg_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          s_axis_tvalid,
    input logic          s_axis_tready,
    input logic          m_axis_tvalid,
    input logic          m_axis_tready,
    input logic [7:0]    m_axis_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // decision is a defined code and the pad is zero
    a_dec_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] <= tlg_pkg::DEC_DROPPED
                          && m_axis_tdata[7:2] == 6'd0)
        else $error("bad decision code");

    // a ready sink never throttles the input side
    a_no_bubble: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled with a ready sink");

    // reset empties the result side
    a_rst_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // an item accepted with the result side empty and a ready sink comes out via the input and result registers
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid && m_axis_tready
        ##1 m_axis_tready |=> m_axis_tvalid)
        else $error("result missing");

endmodule

bind toggle_request_guard tlg_checker u_tlg_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
